// File: sv/timer_deadline_queue_top_assert.svh
// Assertion macros for the timer deadline queue.
`ifndef TIMER_DEADLINE_QUEUE_TOP_ASSERT_SVH
`define TIMER_DEADLINE_QUEUE_TOP_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle.
`define TDQ_ASSERT_IMPL(label, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("tdq check failed");

// Check that a condition implies a consequence in the next cycle.
`define TDQ_ASSERT_NEXT(label, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("tdq check failed");

`endif

// File: sv/tdq_pkg.sv
// Package with types, codes and constants for the timer deadline queue.
package tdq_pkg;

  localparam int NUM_TIMERS_DEF = 16;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_ARM_AB = 3'd1,
    OP_ARM_RE = 3'd2,
    OP_CANCEL = 3'd3,
    OP_SET    = 3'd4
  } op_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [3:0]  timer_id;
    logic [31:0] time_value;
    logic [31:0] period;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  slot_out;
    logic        fired;
    logic        status;
    logic [31:0] tick_now;
    logic        last;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_FIND,
    ST_SHIFT_DN,
    ST_SCAN,
    ST_SHIFT_UP,
    ST_PLACE,
    ST_TICK_HEAD,
    ST_TICK_RELOAD,
    ST_EMIT,
    ST_WAIT
  } state_t;

  // Wrap-aware: a is after b when bit 31 of (b - a) is set.
  function automatic logic is_after(logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    d = b - a;
    return d[31];
  endfunction

endpackage

// File: sv/tdq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module tdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/timer_deadline_queue_top.sv
// Top level of the timer deadline queue: sequencer, list, slot memories.
//
// Channel | Signals                     | Transfer
// in      | in_valid, in_ready, in_item | in_valid && in_ready
// out     | out_valid, out_ready, out   | out_valid && out_ready
//
// One item at a time. Arm, cancel and tick walk the list one entry at a
// time, reading deadlines from the deadline memory for the ordered insert.
// Reset (rst, synchronous) empties the list and clears the tick counter.
// Each result waits in the output register until taken; no item is accepted
// until the last result of the current one has been transferred.
module timer_deadline_queue_top #(
  parameter int NUM_TIMERS = tdq_pkg::NUM_TIMERS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  tdq_pkg::in_item_t in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output tdq_pkg::out_item_t out
);

  localparam int IW = $clog2(NUM_TIMERS);
  localparam int LW = $clog2(NUM_TIMERS + 1);

  tdq_pkg::state_t state, state_next;

  logic [31:0] tick_count, tick_count_next;
  logic [NUM_TIMERS-1:0] linked, linked_next;
  logic [IW-1:0] order_list [NUM_TIMERS];
  logic [LW-1:0] list_length, list_length_next;
  tdq_pkg::in_item_t cur, cur_next;
  logic [IW-1:0] slot, slot_next;
  logic [LW-1:0] pos, pos_next;
  logic [31:0] new_dl, new_dl_next;
  logic [LW-1:0] fire_cnt, fire_cnt_next;
  logic do_insert, do_insert_next;
  tdq_pkg::out_item_t out_next;
  logic out_valid_next;

  // List write port
  logic          lw_en;
  logic [IW-1:0] lw_addr;
  logic [IW-1:0] lw_data;

  // Deadline and period memories
  logic          dl_we, per_we;
  logic [IW-1:0] dl_waddr, dl_raddr, per_raddr;
  logic [31:0]   dl_wdata, dl_rdata, per_rdata;
  logic          rd_pend, rd_pend_next;

  logic in_range;
  logic [IW-1:0] pos_ix;

  tdq_ram #(.WIDTH(32), .DEPTH(NUM_TIMERS)) u_dl (
    .clk(clk), .we(dl_we), .waddr(dl_waddr), .wdata(dl_wdata),
    .raddr(dl_raddr), .rdata(dl_rdata)
  );

  tdq_ram #(.WIDTH(32), .DEPTH(NUM_TIMERS)) u_per (
    .clk(clk), .we(per_we), .waddr(dl_waddr), .wdata(cur.period),
    .raddr(per_raddr), .rdata(per_rdata)
  );

  assign in_ready = (state == tdq_pkg::ST_IDLE) && !out_valid;
  assign in_range = ({28'd0, cur.timer_id} < 32'(NUM_TIMERS));
  assign pos_ix   = pos[IW-1:0];

  // State and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= tdq_pkg::ST_IDLE;
      tick_count  <= '0;
      linked      <= '0;
      list_length <= '0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      tick_count  <= tick_count_next;
      linked      <= linked_next;
      list_length <= list_length_next;
      out_valid   <= out_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cur       <= cur_next;
    slot      <= slot_next;
    pos       <= pos_next;
    new_dl    <= new_dl_next;
    fire_cnt  <= fire_cnt_next;
    do_insert <= do_insert_next;
    rd_pend   <= rd_pend_next;
    out       <= out_next;
    if (lw_en) begin
      order_list[lw_addr] <= lw_data;
    end
  end

  // Sequencer
  always_comb begin
    state_next       = state;
    tick_count_next  = tick_count;
    linked_next      = linked;
    list_length_next = list_length;
    cur_next         = cur;
    slot_next        = slot;
    pos_next         = pos;
    new_dl_next      = new_dl;
    fire_cnt_next    = fire_cnt;
    do_insert_next   = do_insert;
    rd_pend_next     = 1'b0;
    out_next         = out;
    out_valid_next   = out_valid;
    lw_en            = 1'b0;
    lw_addr          = pos_ix;
    lw_data          = slot;
    dl_we            = 1'b0;
    per_we           = 1'b0;
    dl_waddr         = slot;
    dl_wdata         = new_dl;
    dl_raddr         = order_list[pos_ix];
    per_raddr        = slot;

    if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end

    unique case (state)
      tdq_pkg::ST_IDLE: begin
        if (in_valid && in_ready) begin
          cur_next      = in_item;
          fire_cnt_next = '0;
          state_next    = tdq_pkg::ST_DECODE;
        end
      end

      tdq_pkg::ST_DECODE: begin
        slot_next      = IW'(cur.timer_id);
        pos_next       = '0;
        do_insert_next = 1'b0;
        unique case (cur.opcode)
          tdq_pkg::OP_TICK: begin
            tick_count_next = tick_count + 32'd1;
            state_next      = tdq_pkg::ST_TICK_HEAD;
          end
          tdq_pkg::OP_ARM_AB, tdq_pkg::OP_ARM_RE: begin
            out_next = '{slot_out: cur.timer_id, fired: 1'b0, status: 1'b0,
                         tick_now: tick_count, last: 1'b1};
            if (in_range) begin
              new_dl_next = (cur.opcode == tdq_pkg::OP_ARM_AB) ? cur.time_value
                            : tick_count + cur.time_value;
              do_insert_next = 1'b1;
              state_next = tdq_pkg::ST_FIND;
            end else begin
              state_next = tdq_pkg::ST_EMIT;
            end
          end
          tdq_pkg::OP_CANCEL: begin
            out_next = '{slot_out: cur.timer_id, fired: 1'b0, status: 1'b1,
                         tick_now: tick_count, last: 1'b1};
            if (in_range && linked[IW'(cur.timer_id)]) begin
              out_next.status = 1'b0;
              state_next = tdq_pkg::ST_FIND;
            end else begin
              state_next = tdq_pkg::ST_EMIT;
            end
          end
          tdq_pkg::OP_SET: begin
            out_next = '{slot_out: 4'd0, fired: 1'b0, status: 1'b0,
                         tick_now: tick_count, last: 1'b1};
            tick_count_next = cur.time_value;
            state_next = tdq_pkg::ST_EMIT;
          end
          default: begin
            out_next = '{slot_out: 4'd0, fired: 1'b0, status: 1'b0,
                         tick_now: tick_count, last: 1'b1};
            state_next = tdq_pkg::ST_EMIT;
          end
        endcase
      end

      // Walk to the slot's list position (skipped if not linked)
      tdq_pkg::ST_FIND: begin
        if (!linked[slot] || pos >= list_length) begin
          pos_next   = '0;
          state_next = do_insert ? tdq_pkg::ST_SCAN : tdq_pkg::ST_EMIT;
          if (do_insert) begin
            dl_we  = 1'b1;
            per_we = (cur.opcode != tdq_pkg::OP_TICK);
          end
        end else if (order_list[pos_ix] == slot) begin
          state_next = tdq_pkg::ST_SHIFT_DN;
        end else begin
          pos_next = pos + 1'b1;
        end
      end

      // Close the gap one entry per cycle
      tdq_pkg::ST_SHIFT_DN: begin
        if (LW'(pos + 1'b1) < list_length) begin
          lw_en    = 1'b1;
          lw_data  = order_list[IW'(pos + 1'b1)];
          pos_next = pos + 1'b1;
        end else begin
          list_length_next    = list_length - 1'b1;
          linked_next[slot]   = 1'b0;
          pos_next            = '0;
          state_next = do_insert ? tdq_pkg::ST_SCAN : tdq_pkg::ST_EMIT;
          if (do_insert) begin
            dl_we  = 1'b1;
            per_we = (cur.opcode != tdq_pkg::OP_TICK);
          end
        end
      end

      // Find the first entry whose deadline is after the new one
      tdq_pkg::ST_SCAN: begin
        if (pos >= list_length) begin
          state_next = tdq_pkg::ST_SHIFT_UP;
          pos_next   = list_length;
        end else if (!rd_pend) begin
          rd_pend_next = 1'b1;
        end else if (tdq_pkg::is_after(dl_rdata, new_dl)) begin
          state_next = tdq_pkg::ST_SHIFT_UP;
          slot_next  = slot;
          new_dl_next = new_dl;
          pos_next   = list_length;
          // remember insertion point in fire_cnt-free register: reuse new_dl
          new_dl_next = {{(32-LW){1'b0}}, pos};
        end else begin
          pos_next = pos + 1'b1;
        end
        if (state_next == tdq_pkg::ST_SHIFT_UP && pos >= list_length) begin
          new_dl_next = {{(32-LW){1'b0}}, list_length};
        end
      end

      // Open a gap from the tail down to the insertion point
      tdq_pkg::ST_SHIFT_UP: begin
        if (pos > new_dl[LW-1:0]) begin
          lw_en    = 1'b1;
          lw_data  = order_list[IW'(pos - 1'b1)];
          pos_next = pos - 1'b1;
        end else begin
          state_next = tdq_pkg::ST_PLACE;
        end
      end

      tdq_pkg::ST_PLACE: begin
        lw_en             = 1'b1;
        lw_data           = slot;
        list_length_next  = list_length + 1'b1;
        linked_next[slot] = 1'b1;
        state_next        = tdq_pkg::ST_EMIT;
      end

      // Check the head for due
      tdq_pkg::ST_TICK_HEAD: begin
        dl_raddr = order_list[0];
        if (!out_valid || out_ready) begin
          if (list_length == '0 || fire_cnt == LW'(NUM_TIMERS)) begin
            state_next = tdq_pkg::ST_WAIT;
          end else if (!rd_pend) begin
            rd_pend_next = 1'b1;
          end else if (!tdq_pkg::is_after(dl_rdata, tick_count) ||
                       dl_rdata == tick_count) begin
            slot_next   = order_list[0];
            new_dl_next = dl_rdata;
            state_next  = tdq_pkg::ST_TICK_RELOAD;
            rd_pend_next = 1'b0;
            // Release the held firing, another one follows
            if (fire_cnt != '0) begin
              out_valid_next = 1'b1;
            end
          end else begin
            state_next = tdq_pkg::ST_WAIT;
          end
        end
      end

      // Read the period, hold the firing, then unlink and, for a nonzero period, reinsert
      tdq_pkg::ST_TICK_RELOAD: begin
        if (!rd_pend) begin
          rd_pend_next = 1'b1;
        end else if (!out_valid || out_ready) begin
          do_insert_next = (per_rdata != 32'd0);
          new_dl_next    = new_dl + per_rdata;
          pos_next       = '0;
          fire_cnt_next  = fire_cnt + 1'b1;
          out_next = '{slot_out: 4'(slot), fired: 1'b1, status: 1'b0,
                       tick_now: tick_count, last: 1'b0};
          state_next = tdq_pkg::ST_FIND;
        end
      end

      // Hand a result to the output register, or go back to the head check in a tick
      tdq_pkg::ST_EMIT: begin
        if (cur.opcode == tdq_pkg::OP_TICK) begin
          state_next = tdq_pkg::ST_TICK_HEAD;
        end else if (!out_valid || out_ready) begin
          out_valid_next = 1'b1;
          state_next     = tdq_pkg::ST_IDLE;
        end
      end

      // Finish a tick: flush the held firing as last, or report none
      tdq_pkg::ST_WAIT: begin
        if (!out_valid || out_ready) begin
          if (fire_cnt == '0) begin
            out_next = '{slot_out: 4'd0, fired: 1'b0, status: 1'b0,
                         tick_now: tick_count, last: 1'b1};
          end else begin
            out_next.last = 1'b1;
          end
          out_valid_next = 1'b1;
          state_next     = tdq_pkg::ST_IDLE;
        end
      end

      default: state_next = tdq_pkg::ST_IDLE;
    endcase
  end

  `include "timer_deadline_queue_top_assert.svh"

  `TDQ_ASSERT_IMPL(a_len_bound, 1'b1, list_length <= LW'(NUM_TIMERS))
  `TDQ_ASSERT_IMPL(a_link_count, state == tdq_pkg::ST_IDLE,
                   LW'($countones(linked)) == list_length)
  `TDQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out))

endmodule
